// ----- rtl/mfde_pkg.sv -----
// Package for the mono framebuffer draw engine: command and pixel op codes,
// default geometry. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mfde_pkg;
  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;
  localparam int DEF_STORE_BYTES   = 1024;

  localparam logic [2:0] REQ_CLEAR = 3'd0;
  localparam logic [2:0] REQ_POINT = 3'd1;
  localparam logic [2:0] REQ_READ  = 3'd2;
  localparam logic [2:0] REQ_BYTE  = 3'd3;
  localparam logic [2:0] REQ_RECT  = 3'd4;
  localparam logic [2:0] REQ_LINE  = 3'd5;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_TOGGLE = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] x_first;
    logic [7:0] y_first;
    logic [7:0] x_second;
    logic [7:0] y_second;
    logic [1:0] pixel_op;
    logic [7:0] byte_data;
    logic [2:0] byte_mode;
  } req_t;

  typedef struct packed {
    logic pixel_value;
    logic rect_error;
  } rsp_t;

  // Apply a set/clear/toggle mask to one byte; an unused op leaves it alone.
  function automatic logic [7:0] apply_op(input logic [7:0] d, input logic [7:0] m,
                                          input logic [1:0] op);
    logic [7:0] r;
    r = d;
    case (op)
      OP_CLEAR:  r = d & ~m;
      OP_SET:    r = d | m;
      OP_TOGGLE: r = d ^ m;
      default:   r = d;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/mfde_if.sv -----
// Valid/ready channel carrying a generic payload.
// Takes the payload type as a parameter; depends on no package.
`timescale 1ns / 1ps
`default_nettype none
interface mfde_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/mono_framebuffer_draw_engine_core.sv -----
// Top level of the mono framebuffer draw engine: command sequencer around
// the frame store. Depends on mfde_pkg, mfde_if and mfde_store.
//
// Usage: commands arrive on req (valid/ready), one result per command
// leaves on rsp. A command is taken only when the engine is idle and the
// result register is empty, so one command is in flight at a time.
// Work is done as read-modify-write passes on the frame store, one pass per
// byte through S_RD, S_WAIT and S_WR (issue read, data back, write):
//   point write : one pass
//   byte write  : one pass per enabled bit, a bare S_WR step per masked bit
//   point read  : S_RD and S_WAIT only, no write
//   rectangle   : one pass per covered byte, S_RD then S_WR per empty page or column run
//   line        : one pass per plot, max(|dx|,|dy|)+2 plots
//   clear       : S_CLR sweep over all STORE_BYTES bytes, one byte written per cycle
// Each command also passes S_PLAN for setup first and S_DONE last, which
// posts the result.
// After reset the engine sweeps zeros into the whole store and accepts no
// command until done. A stalled receiver holds the result in its register,
// and no new command is taken until it leaves.
`timescale 1ns / 1ps
`default_nettype none
module mono_framebuffer_draw_engine_core
  import mfde_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int STORE_BYTES   = DEF_STORE_BYTES
) (
  input wire logic clk,
  input wire logic rst,
  mfde_if.sink     req,
  mfde_if.source   rsp
);
  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [8:0] W9 = 9'(SCREEN_WIDTH);
  localparam logic [8:0] H9 = 9'(SCREEN_HEIGHT);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_PLAN, S_RD, S_WAIT, S_WR, S_DONE} state_t;
  state_t state;

  req_t        cmd;
  logic [AW:0] clr_cnt;
  logic        clr_rsp;           // sweep was started by a clear command
  // current pixel or byte position
  logic [8:0]  cx, cy;            // cy used as pixel row (point/read/line/byte) or page (rect)
  logic [7:0]  cur_mask;
  logic [1:0]  cur_op;
  logic [2:0]  bit_i;             // byte write bit index
  // line stepping
  logic [8:0]  ldx, ldy, ldist, lex, ley;
  logic        lsx, lsy;
  logic [9:0]  lcnt;
  // rect walk
  logic [7:0]  rxe;
  logic [16:0] mul_addr;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]  rd_data, wr_data;
  logic        wr_en;
  logic        rsp_full;
  rsp_t        rsp_q;
  logic        hit;               // current byte is on screen and in store

  // byte address of (cx, page)
  logic [8:0] page;
  always_comb begin
    page     = (cmd.req_type == REQ_RECT) ? cy : {3'd0, cy[8:3]};
    mul_addr = 17'(cx) + 17'(SCREEN_WIDTH) * 17'(page);
    hit = (cx < W9) && (mul_addr < 17'(STORE_BYTES));
    if (cmd.req_type != REQ_RECT) hit = hit && (cy < H9);
  end
  assign rd_addr = mul_addr[AW-1:0];
  assign req.ready = (state == S_IDLE) && !rsp_full;
  assign rsp.valid = rsp_full;
  assign rsp.data  = rsp_q;

  // line length in steps
  always_comb begin
    ldist = (ldx > ldy) ? ldx : ldy;
  end

  // rect page mask for page cy
  logic [8:0] plo, phi;
  logic [7:0] pmask;
  always_comb begin
    plo = {cy[5:0], 3'd0};
    if (plo < {1'b0, cmd.y_first}) plo = {1'b0, cmd.y_first};
    phi = {cy[5:0], 3'd7};
    if (phi > {1'b0, cmd.y_second}) phi = {1'b0, cmd.y_second};
    if (phi > H9 - 9'd1) phi = H9 - 9'd1;
    pmask = (8'hff << plo[2:0]) & (8'hff >> (3'd7 - phi[2:0]));
  end

  // byte-write helpers
  logic [7:0] bw_en, bw_val;
  always_comb begin
    if (!cmd.byte_mode[2]) bw_en = 8'hff;
    else if (!cmd.byte_mode[0]) bw_en = ~cmd.byte_data;
    else bw_en = cmd.byte_data;
    bw_val = cmd.byte_mode[1] ? ~cmd.byte_data : cmd.byte_data;
  end

  mfde_store #(.STORE_BYTES(STORE_BYTES)) u_store (
    .clk(clk), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      state    <= S_CLR;
      clr_cnt  <= '0;
      clr_rsp  <= 1'b0;
      rsp_full <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp_full <= 1'b0;
      case (state)
        S_CLR: begin
          // sweep zeros through the store
          wr_en   <= 1'b1;
          wr_addr <= clr_cnt[AW-1:0];
          wr_data <= 8'h00;
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(STORE_BYTES - 1)) begin
            if (clr_rsp) state <= S_DONE;
            else state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cmd     <= req.data;
            state   <= S_PLAN;
            rsp_q   <= '0;
            clr_rsp <= 1'b0;
          end
        end
        S_PLAN: begin
          // set up the first byte pass of the command, or start a clear sweep or post a rect error
          cx     <= {1'b0, cmd.x_first};
          cy     <= {1'b0, cmd.y_first};
          cur_op <= cmd.pixel_op;
          cur_mask <= 8'd1 << cmd.y_first[2:0];
          bit_i  <= 3'd0;
          ldx <= (cmd.x_second >= cmd.x_first) ? 9'(cmd.x_second - cmd.x_first)
                                                : 9'(cmd.x_first - cmd.x_second);
          ldy <= (cmd.y_second >= cmd.y_first) ? 9'(cmd.y_second - cmd.y_first)
                                                : 9'(cmd.y_first - cmd.y_second);
          lsx <= cmd.x_second < cmd.x_first;
          lsy <= cmd.y_second < cmd.y_first;
          lex <= '0; ley <= '0; lcnt <= '0;
          rxe <= (9'(cmd.x_second) > W9 - 9'd1) ? 8'(W9 - 9'd1) : cmd.x_second;
          case (cmd.req_type)
            REQ_CLEAR: begin
              clr_cnt <= '0;
              clr_rsp <= 1'b1;
              state   <= S_CLR;
            end
            REQ_POINT, REQ_LINE, REQ_READ: state <= S_RD;
            REQ_BYTE: begin
              cur_op   <= {1'b0, bw_val[0]};
              state    <= bw_en[0] ? S_RD : S_WR;
            end
            REQ_RECT: begin
              if (cmd.x_first > cmd.x_second || cmd.y_first > cmd.y_second) begin
                rsp_q.rect_error <= 1'b1;
                state <= S_DONE;
              end else begin
                cy    <= {4'd0, cmd.y_first[7:3]};
                state <= S_RD;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_RD: begin
          // read issued by address; mask fixed for rect
          if (cmd.req_type == REQ_RECT) cur_mask <= pmask;
          if (cmd.req_type == REQ_RECT && (plo > phi || cx > {1'b0, rxe}))
            state <= S_WR;
          else state <= S_WAIT;
        end
        S_WAIT: begin
          if (cmd.req_type == REQ_READ) begin
            rsp_q.pixel_value <= hit & rd_data[cy[2:0]];
            state <= S_DONE;
          end else begin
            if (hit) begin
              wr_en   <= 1'b1;
              wr_addr <= rd_addr;
              wr_data <= apply_op(rd_data, cur_mask, cur_op);
            end
            state <= S_WR;
          end
        end
        S_WR: begin
          // advance to the next byte pass
          state <= S_RD;
          case (cmd.req_type)
            REQ_BYTE: begin
              if (bit_i == 3'd7 || 9'(cmd.y_first) + 9'(bit_i) == 9'd255) state <= S_DONE;
              else begin
                bit_i    <= bit_i + 3'd1;
                cy       <= cy + 9'd1;
                cur_mask <= 8'd1 << (cy[2:0] + 3'd1);
                cur_op   <= {1'b0, bw_val[bit_i + 3'd1]};
                if (!bw_en[bit_i + 3'd1]) state <= S_WR;
              end
            end
            REQ_RECT: begin
              if (cx < {1'b0, rxe} && plo <= phi) cx <= cx + 9'd1;
              else if (cy[4:0] == cmd.y_second[7:3]) state <= S_DONE;
              else begin
                cx <= {1'b0, cmd.x_first};
                cy <= cy + 9'd1;
              end
            end
            REQ_LINE: begin
              if (lcnt == {1'b0, ldist} + 10'd1) state <= S_DONE;
              else begin
                lcnt <= lcnt + 10'd1;
                if (lex + ldx > ldist) begin
                  lex <= lex + ldx - ldist;
                  cx  <= lsx ? cx - 9'd1 : cx + 9'd1;
                end else lex <= lex + ldx;
                if (ley + ldy > ldist) begin
                  ley <= ley + ldy - ldist;
                  cy  <= lsy ? cy - 9'd1 : cy + 9'd1;
                  cur_mask <= 8'd1 << (lsy ? cy[2:0] - 3'd1 : cy[2:0] + 3'd1);
                end else ley <= ley + ldy;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_DONE: begin
          rsp_full <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/mfde_store.sv -----
// Frame store memory: one write port, one registered read port.
// Depends on mfde_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfde_store
  import mfde_pkg::*;
#(
  parameter int STORE_BYTES = DEF_STORE_BYTES,
  localparam int AW = $clog2(STORE_BYTES)
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data
);
  logic [7:0] mem [STORE_BYTES];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- rtl/mfde_checker.sv -----
// Port-level checks for the draw engine, bound to the top level.
// Depends on mfde_pkg and mfde_if.
`timescale 1ns / 1ps
`default_nettype none
module mfde_checker
  import mfde_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp_data
);
  // no command taken while a result is pending
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready) else $error("take with full result");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_data.pixel_value && rsp_data.rect_error)) else $error("both flags");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid || rsp_ready || $past(rsp_valid))
    else $error("result too early");
endmodule

bind mono_framebuffer_draw_engine_core mfde_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking bench for the mono framebuffer draw engine core.
// Depends on mfde_pkg, mfde_if and the engine RTL; keeps a shadow frame store.
`timescale 1ns / 1ps
module testbench;
  import mfde_pkg::*;

  localparam int SW = DEF_SCREEN_WIDTH;
  localparam int SH = DEF_SCREEN_HEIGHT;
  localparam int SB = DEF_STORE_BYTES;
  localparam int RANDOM_CMDS = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  mfde_if #(.payload_t(req_t)) req (.clk(clk));
  mfde_if #(.payload_t(rsp_t)) rsp (.clk(clk));

  mono_framebuffer_draw_engine_core u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  // Shadow picture of the frame store, and results still owed by the engine.
  logic [7:0] shadow_fb [SB];
  rsp_t       owed_rsp [$];
  int         fail_cnt = 0;
  bit         stim_done = 1'b0;
  bit         hold_off = 1'b0;

  function automatic void shadow_mask(int x, int page, logic [7:0] m, logic [1:0] op);
    int a;
    a = x + SW * page;
    if (a >= SB) return;
    case (op)
      OP_CLEAR:  shadow_fb[a] = shadow_fb[a] & ~m;
      OP_SET:    shadow_fb[a] = shadow_fb[a] | m;
      OP_TOGGLE: shadow_fb[a] = shadow_fb[a] ^ m;
      default:   ;
    endcase
  endfunction

  function automatic void shadow_plot(int x, int y, logic [1:0] op);
    if (x < 0 || y < 0 || x >= SW || y >= SH) return;
    shadow_mask(x, y >> 3, 8'(1 << (y & 7)), op);
  endfunction

  // Apply one command to the shadow store and return the result it owes.
  function automatic rsp_t draw_predict(req_t c);
    rsp_t r;
    int en, val, lo, hi, xe, dx, dy, sx, sy, span, ex, ey, cx, cy;
    r = '0;
    case (c.req_type)
      REQ_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      REQ_POINT: shadow_plot(c.x_first, c.y_first, c.pixel_op);
      REQ_READ:
        if (c.x_first < SW && c.y_first < SH)
          r.pixel_value = shadow_fb[c.x_first + SW * (c.y_first >> 3)][c.y_first & 7];
      REQ_BYTE: begin
        if (!c.byte_mode[2]) en = 8'hff;
        else if (!c.byte_mode[0]) en = c.byte_data ^ 8'hff;
        else en = c.byte_data;
        val = c.byte_mode[1] ? (c.byte_data ^ 8'hff) : c.byte_data;
        for (int i = 0; i < 8; i++)
          if (en[i] && c.y_first + i <= 255)
            shadow_plot(c.x_first, c.y_first + i, {1'b0, val[i]});
      end
      REQ_RECT: begin
        if (c.x_first > c.x_second || c.y_first > c.y_second) begin
          r.rect_error = 1'b1;
        end else begin
          xe = (c.x_second > SW - 1) ? SW - 1 : c.x_second;
          for (int p = c.y_first >> 3; p <= (c.y_second >> 3); p++) begin
            lo = (p * 8 < c.y_first) ? c.y_first : p * 8;
            hi = (p * 8 + 7 > c.y_second) ? c.y_second : p * 8 + 7;
            if (hi > SH - 1) hi = SH - 1;
            if (lo <= hi)
              for (int x = c.x_first; x <= xe; x++)
                shadow_mask(x, p, 8'((8'hff << (lo & 7)) & (8'hff >> (7 - (hi & 7)))),
                            c.pixel_op);
          end
        end
      end
      REQ_LINE: begin
        dx = int'(c.x_second) - int'(c.x_first);
        dy = int'(c.y_second) - int'(c.y_first);
        sx = (dx > 0) ? 1 : (dx < 0) ? -1 : 0;
        sy = (dy > 0) ? 1 : (dy < 0) ? -1 : 0;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        span = (dx > dy) ? dx : dy;
        ex = 0; ey = 0; cx = c.x_first; cy = c.y_first;
        for (int t = 0; t <= span + 1; t++) begin
          shadow_plot(cx, cy, c.pixel_op);
          ex += dx; ey += dy;
          if (ex > span) begin ex -= span; cx += sx; end
          if (ey > span) begin ey -= span; cy += sy; end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Directed rows: command plus, where obvious, the result typed in.
  typedef struct {
    req_t c;
    bit   known;
    rsp_t r;
  } dir_row_t;

  function automatic req_t mk(logic [2:0] t, logic [7:0] xa, logic [7:0] ya,
                              logic [7:0] xb, logic [7:0] yb, logic [1:0] op,
                              logic [7:0] d, logic [2:0] m);
    req_t c;
    c = '{t, xa, ya, xb, yb, op, d, m};
    return c;
  endfunction

  dir_row_t dir_tab [$];
  initial begin
    dir_tab = '{
      '{mk(REQ_READ,  0,   0,   0,   0, OP_SET,    0, 0), 1, '{1'b0, 1'b0}},
      '{mk(REQ_READ,  127, 63,  0,   0, OP_SET,    0, 0), 1, '{1'b0, 1'b0}},
      '{mk(REQ_POINT, 0,   0,   0,   0, OP_SET,    0, 0), 1, '{1'b0, 1'b0}},
      '{mk(REQ_READ,  0,   0,   0,   0, OP_CLEAR,  0, 0), 1, '{1'b1, 1'b0}},
      '{mk(REQ_POINT, 127, 63,  0,   0, OP_TOGGLE, 0, 0), 1, '{1'b0, 1'b0}},
      '{mk(REQ_READ,  127, 63,  0,   0, OP_SET,    0, 0), 1, '{1'b1, 1'b0}},
      '{mk(REQ_POINT, 255, 255, 0,   0, OP_SET,    0, 0), 0, '{1'b0, 1'b0}},
      '{mk(REQ_READ,  255, 255, 0,   0, OP_SET,    0, 0), 1, '{1'b0, 1'b0}},
      '{mk(REQ_POINT, 5,   5,   0,   0, 2'd3,      0, 0), 0, '{1'b0, 1'b0}},
      '{mk(REQ_BYTE,  10,  3,   0,   0, OP_SET, 8'hA5, 0), 0, '{1'b0, 1'b0}},
      '{mk(REQ_BYTE,  11,  60,  0,   0, OP_SET, 8'hff, 3'd2), 0, '{1'b0, 1'b0}},
      '{mk(REQ_BYTE,  12,  252, 0,   0, OP_SET, 8'hff, 3'd5), 0, '{1'b0, 1'b0}},
      '{mk(REQ_BYTE,  10,  0,   0,   0, OP_SET, 8'h0f, 3'd4), 0, '{1'b0, 1'b0}},
      '{mk(REQ_BYTE,  10,  0,   0,   0, OP_SET, 8'h3c, 3'd7), 0, '{1'b0, 1'b0}},
      '{mk(REQ_RECT,  20,  10,  19,  12, OP_SET, 0, 0), 1, '{1'b0, 1'b1}},
      '{mk(REQ_RECT,  20,  12,  22,  10, OP_SET, 0, 0), 1, '{1'b0, 1'b1}},
      '{mk(REQ_RECT,  3,   5,   9,   21, OP_SET, 0, 0), 0, '{1'b0, 1'b0}},
      '{mk(REQ_RECT,  120, 60,  255, 255, OP_TOGGLE, 0, 0), 0, '{1'b0, 1'b0}},
      '{mk(REQ_RECT,  4,   6,   6,   6, OP_CLEAR, 0, 0), 0, '{1'b0, 1'b0}},
      '{mk(REQ_LINE,  0,   0,   127, 63, OP_TOGGLE, 0, 0), 0, '{1'b0, 1'b0}},
      '{mk(REQ_LINE,  30,  30,  30,  30, OP_TOGGLE, 0, 0), 0, '{1'b0, 1'b0}},
      '{mk(REQ_LINE,  200, 10,  100, 70, OP_SET, 0, 0), 0, '{1'b0, 1'b0}},
      '{mk(3'd6,      1,   1,   2,   2, OP_SET, 0, 0), 1, '{1'b0, 1'b0}},
      '{mk(3'd7,      1,   1,   2,   2, OP_SET, 0, 0), 1, '{1'b0, 1'b0}},
      '{mk(REQ_CLEAR, 0,   0,   0,   0, OP_SET, 0, 0), 1, '{1'b0, 1'b0}},
      '{mk(REQ_READ,  0,   0,   0,   0, OP_SET, 0, 0), 1, '{1'b0, 1'b0}}
    };
  end

  function automatic int gap_len();
    return ($urandom_range(0, 99) < 70) ? 0 :
           ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 60);
  endfunction

  // Random command: mostly on-screen coordinates, some anywhere; short lines
  // and small rectangles most of the time to keep the run brisk.
  function automatic req_t rand_cmd();
    req_t c;
    int pick;
    c.req_type  = 3'($urandom_range(0, 99) < 2 ? REQ_CLEAR : $urandom_range(1, 7));
    if (c.req_type == REQ_CLEAR && $urandom_range(0, 1)) c.req_type = REQ_READ;
    pick = $urandom_range(0, 9);
    c.x_first   = (pick < 8) ? 8'($urandom_range(0, SW - 1)) : 8'($urandom);
    c.y_first   = (pick < 8) ? 8'($urandom_range(0, SH - 1)) : 8'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      c.x_second = 8'(c.x_first + $urandom_range(0, 12) - ($urandom_range(0, 4) == 0 ? 6 : 0));
      c.y_second = 8'(c.y_first + $urandom_range(0, 12) - ($urandom_range(0, 4) == 0 ? 6 : 0));
    end else begin
      c.x_second = 8'($urandom);
      c.y_second = 8'($urandom);
    end
    c.pixel_op  = 2'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
    c.byte_data = 8'($urandom);
    c.byte_mode = 3'($urandom);
    return c;
  endfunction

  // Offer one command and hold it until the transfer; predict at acceptance.
  // Valid drops only for a gap, so back-to-back commands keep it high.
  task automatic send_cmd(req_t c, bit known, rsp_t r);
    rsp_t p;
    int g;
    g = gap_len();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= c;
    do @(posedge clk); while (!req.ready);
    p = draw_predict(c);
    if (known && p != r)
      $display("%0t directed row table disagrees: typed %b predicted %b", $time, r, p);
    owed_rsp.push_back(known ? r : p);
  endtask

  initial begin
    req.valid = 1'b0;
    req.data  = '0;
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) send_cmd(dir_tab[i].c, dir_tab[i].known, dir_tab[i].r);
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      // Hold the receiver off mid-run while a command is still being offered.
      if (n == 400) hold_off = 1'b1;
      send_cmd(rand_cmd(), 1'b0, '0);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls plus one long hold-off stretch.
  initial begin
    int g;
    bit stall_done;
    stall_done = 1'b0;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off && !stall_done) begin
        rsp.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        stall_done = 1'b1;
      end
      g = gap_len();
      if (g > 0) begin
        rsp.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Check every result transfer against the oldest owed result.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (owed_rsp.size() == 0) begin
        $display("%0t unexpected result %b", $time, rsp.data);
        fail_cnt++;
      end else begin
        if (rsp.data.pixel_value !== owed_rsp[0].pixel_value) begin
          $display("%0t pixel_value expected %b actual %b", $time,
                   owed_rsp[0].pixel_value, rsp.data.pixel_value);
          fail_cnt++;
        end
        if (rsp.data.rect_error !== owed_rsp[0].rect_error) begin
          $display("%0t rect_error expected %b actual %b", $time,
                   owed_rsp[0].rect_error, rsp.data.rect_error);
          fail_cnt++;
        end
        void'(owed_rsp.pop_front());
      end
    end
  end

  initial begin
    wait (stim_done);
    while (owed_rsp.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (fail_cnt == 0 && owed_rsp.size() == 0)
      $display("mono_framebuffer_draw_engine_core regression: pass");
    else
      $display("mono_framebuffer_draw_engine_core regression: fail");
    $finish;
  end

  initial begin
    #200ms;
    $display("mono_framebuffer_draw_engine_core regression: fail");
    $finish;
  end
endmodule
